[rtl/sle_pkg.sv]
// ============================================================================
// sle_pkg
// Shared constants, types and key tables for the scan-code line editor.
// ============================================================================
package sle_pkg;

    // Line buffer geometry.
    localparam int LINE_DEPTH = 62;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // Scan-set-1 key codes (press form, bit 7 clear).
    localparam int               KEY_W         = 7;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 7'd14;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 7'd28;
    localparam logic [KEY_W-1:0] KEY_CTRL      = 7'd29;
    localparam logic [KEY_W-1:0] KEY_LSHIFT    = 7'd42;
    localparam logic [KEY_W-1:0] KEY_RSHIFT    = 7'd54;
    localparam logic [KEY_W-1:0] KEY_ALT       = 7'd56;
    localparam logic [KEY_W-1:0] KEY_CAPS      = 7'd58;
    localparam logic [KEY_W-1:0] KEY_MAX       = 7'd58;

    localparam int TABLE_LEN = 59;
    localparam int IDX_W     = 6;

    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
    localparam logic [6:0] CHAR_FILL    = 7'h3F;
    localparam logic [6:0] CASE_BIT     = 7'h20;

    // Key tables, entry 0 in the highest byte.
    localparam logic [8*TABLE_LEN-1:0] PLAIN_MAP =
        "??1234567890-=\010\011qwertyuiop[]\012?asdfghjkl;'`?\\zxcvbnm,./??? ?";
    localparam logic [8*TABLE_LEN-1:0] SHIFT_MAP =
        "..!@#$%^&*()_+\010\011QWERTYUIOP{}\012.ASDFGHJKL:\"~.|ZXCVBNM<>?.*. ?";

    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_BACKSPACE = 3'd1,
        KIND_LINE_CHAR = 3'd2,
        KIND_LINE_END  = 3'd3,
        KIND_DROPPED   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LINE_RD,
        ST_LINE_OUT,
        ST_LINE_END
    } state_t;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_flags_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [6:0]        data;
    } line_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } line_rd_t;

    function automatic logic [6:0] table_char(input logic [8*TABLE_LEN-1:0] map,
                                              input logic [IDX_W-1:0] idx);
        logic [7:0] byte_val;
        byte_val = 8'h3F;
        if (idx <= KEY_MAX[IDX_W-1:0]) begin
            byte_val = map[8*(TABLE_LEN - 1 - int'(idx)) +: 8];
        end
        return byte_val[6:0];
    endfunction

endpackage

[rtl/sle_line_ram.sv]
// ============================================================================
// sle_line_ram
// Line buffer storage: one write port, one registered read port.
// ============================================================================
module sle_line_ram (
    input  logic             aclk,
    input  sle_pkg::line_wr_t wr,
    input  sle_pkg::line_rd_t rd,
    output logic [6:0]       rd_data
);
    import sle_pkg::*;

    logic [6:0] line_mem [LINE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            line_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= line_mem[rd.addr];
        end
    end

endmodule

[rtl/sle_key_map.sv]
// ============================================================================
// sle_key_map
// Maps a press code to ASCII using shift and caps lock.
// ============================================================================
module sle_key_map (
    input  logic [sle_pkg::IDX_W-1:0] key_idx,
    input  sle_pkg::mod_flags_t       flags,
    output logic [6:0]                char_code
);
    import sle_pkg::*;

    logic [6:0] plain_c;
    logic [6:0] shift_c;

    always_comb begin
        plain_c = table_char(PLAIN_MAP, key_idx);
        shift_c = table_char(SHIFT_MAP, key_idx);
        if (flags.shift) begin
            // Caps with shift gives lower-case letters.
            if (flags.caps && shift_c >= 7'h41 && shift_c <= 7'h5A) begin
                char_code = shift_c ^ CASE_BIT;
            end else begin
                char_code = shift_c;
            end
        end else begin
            if (flags.caps && plain_c >= 7'h61 && plain_c <= 7'h7A) begin
                char_code = plain_c ^ CASE_BIT;
            end else begin
                char_code = plain_c;
            end
        end
    end

endmodule

[rtl/scancode_line_editor.sv]
// ============================================================================
// scancode_line_editor
// Line editor fed by scan-set-1 bytes: tracks modifiers, echoes keys and
// holds the typed line in a small RAM, emitting it on enter when line output is enabled.
// ============================================================================
//
//  Channel | Direction | Payload
//  --------+-----------+----------------------------------------------------
//  s_      | in        | tdata[7:0] scancode
//  m_      | out       | tdata[6:0] char, [7] ctrl, [8] alt; tuser kind; tlast
//  cfg_    | in        | data[0] line_output_enable
//
//  One item is handled at a time. An item is taken in one cycle and decoded
//  in the next; a result waits for m_tready while the output register is
//  full. Enter with output enabled then reads each buffered character from
//  the registered read port of the line RAM (ST_LINE_RD) and sends it
//  (ST_LINE_OUT), then finds the end of the line and sends the end marker
//  (ST_LINE_END).
//  Reset is synchronous, active low, and clears flags, length and control;
//  the line RAM is not cleared since only written entries are ever read.
//  The output register lets the next item be taken while a result waits.
//
module scancode_line_editor (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] char_code, [7] ctrl_down, [8] alt_down
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,   // last result of the item

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // [0] line_output_enable
);
    import sle_pkg::*;

    state_t           state_reg, state_next;
    logic [7:0]       code_reg;
    mod_flags_t       flags_reg, flags_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             enable_reg;

    // Output register.
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [6:0] out_char_reg;
    logic       out_last_reg;
    logic       out_ctrl_reg;
    logic       out_alt_reg;

    logic       out_load;
    kind_t      out_kind_next;
    logic [6:0] out_char_next;
    logic       out_last_next;
    logic       out_free;

    line_wr_t   ram_wr;
    line_rd_t   ram_rd;
    logic [6:0] ram_rd_data;
    logic [6:0] mapped_char;

    logic [KEY_W-1:0] press_code;
    logic             is_release;
    logic             is_ignored;
    logic             line_full;

    assign press_code = code_reg[KEY_W-1:0];
    assign is_release = code_reg[7];
    assign is_ignored = !is_release && (press_code > KEY_MAX);
    assign line_full  = (len_reg >= LEN_W'(LINE_DEPTH));
    assign out_free   = !out_valid_reg || m_tready;

    sle_key_map u_key_map (
        .key_idx   (press_code[IDX_W-1:0]),
        .flags     (flags_reg),
        .char_code (mapped_char)
    );

    sle_line_ram u_line_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // The configuration register is always writable; the user must change it only
    // while the editor is idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            enable_reg <= cfg_data[0];
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (is_release || is_ignored) begin
                    state_next = ST_IDLE;
                end else begin
                    case (press_code)
                        KEY_BACKSPACE: begin
                            if (len_reg == '0 || out_free) begin
                                state_next = ST_IDLE;
                            end
                        end
                        KEY_ENTER: begin
                            if (out_free) begin
                                state_next = enable_reg ? ST_LINE_RD : ST_IDLE;
                            end
                        end
                        KEY_LSHIFT, KEY_RSHIFT, KEY_CTRL, KEY_ALT, KEY_CAPS: begin
                            state_next = ST_IDLE;
                        end
                        default: begin
                            if (out_free) begin
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_LINE_RD: begin
                state_next = (idx_reg == len_reg) ? ST_LINE_END : ST_LINE_OUT;
            end
            ST_LINE_OUT: begin
                if (out_free) begin
                    state_next = ST_LINE_RD;
                end
            end
            ST_LINE_END: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb begin
        s_tready      = 1'b0;
        out_load      = 1'b0;
        out_kind_next = KIND_ECHO;
        out_char_next = '0;
        out_last_next = 1'b0;
        flags_next    = flags_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        ram_wr.en     = 1'b0;
        ram_wr.addr   = len_reg[ADDR_W-1:0];
        ram_wr.data   = mapped_char;
        ram_rd.en     = 1'b0;
        ram_rd.addr   = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_DECODE: begin
                if (is_release) begin
                    // Releases only clear modifiers; caps is a toggle.
                    if (press_code == KEY_LSHIFT || press_code == KEY_RSHIFT) begin
                        flags_next.shift = 1'b0;
                    end else if (press_code == KEY_CTRL) begin
                        flags_next.ctrl = 1'b0;
                    end else if (press_code == KEY_ALT) begin
                        flags_next.alt = 1'b0;
                    end
                end else if (!is_ignored) begin
                    case (press_code)
                        KEY_BACKSPACE: begin
                            if (len_reg != '0 && out_free) begin
                                out_load      = 1'b1;
                                out_kind_next = KIND_BACKSPACE;
                                out_last_next = 1'b1;
                                len_next      = len_reg - LEN_W'(1);
                            end
                        end
                        KEY_ENTER: begin
                            if (out_free) begin
                                out_load      = 1'b1;
                                out_kind_next = KIND_ECHO;
                                out_char_next = CHAR_NEWLINE;
                                out_last_next = !enable_reg;
                                idx_next      = '0;
                                if (!enable_reg) begin
                                    len_next = '0;
                                end
                            end
                        end
                        KEY_LSHIFT, KEY_RSHIFT: begin
                            flags_next.shift = 1'b1;
                        end
                        KEY_CTRL: begin
                            flags_next.ctrl = 1'b1;
                        end
                        KEY_ALT: begin
                            flags_next.alt = 1'b1;
                        end
                        KEY_CAPS: begin
                            flags_next.caps = !flags_reg.caps;
                        end
                        default: begin
                            if (out_free) begin
                                out_load      = 1'b1;
                                out_char_next = mapped_char;
                                out_last_next = 1'b1;
                                if (line_full) begin
                                    out_kind_next = KIND_DROPPED;
                                end else begin
                                    out_kind_next = KIND_ECHO;
                                    ram_wr.en     = 1'b1;
                                    len_next      = len_reg + LEN_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            ST_LINE_RD: begin
                ram_rd.en = (idx_reg != len_reg);
            end
            ST_LINE_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_LINE_CHAR;
                    out_char_next = ram_rd_data;
                    idx_next      = idx_reg + LEN_W'(1);
                end
            end
            ST_LINE_END: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_LINE_END;
                    out_last_next = 1'b1;
                    len_next      = '0;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flags_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            code_reg <= s_tdata;
        end
    end

    // Result register: a new result loads only when the slot is empty or
    // is being taken in this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg <= out_kind_next;
            out_char_reg <= out_char_next;
            out_last_reg <= out_last_next;
            out_ctrl_reg <= flags_reg.ctrl;
            out_alt_reg  <= flags_reg.alt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_alt_reg, out_ctrl_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

[verif/tb_scancode_line_editor.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_scancode_line_editor
// Self-checking bench for the scan-code line editor. A scoreboard class tracks
// modifier flags, caps lock and the typed line, and works out every echo, line
// and dropped item that each accepted scan byte must produce. Directed keys come
// first, then random typing sessions under changing back-pressure.
// ============================================================================
module tb_scancode_line_editor;
    import sle_pkg::*;

    // Time budget and drain waits, in clock cycles.
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int SETTLE_WAIT  = 8;     // settle time for an item with no result
    localparam int FINAL_WAIT   = 140;   // longer than a full enter with output on

    // Key tables, entry 0 in the highest byte. The tab, backspace and newline
    // entries are written as octal escapes.
    localparam bit [8*TABLE_LEN-1:0] UNSHIFTED_KEYS =
        "??1234567890-=\010\011qwertyuiop[]\012?asdfghjkl;'`?\\zxcvbnm,./??? ?";
    localparam bit [8*TABLE_LEN-1:0] SHIFTED_KEYS =
        "..!@#$%^&*()_+\010\011QWERTYUIOP{}\012.ASDFGHJKL:\"~.|ZXCVBNM<>?.*. ?";

    // One item as the editor should emit it.
    typedef struct {
        kind_t      kind;
        bit [6:0]   char_code;
        bit         last;
        bit         ctrl_down;
        bit         alt_down;
    } line_event_t;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the editor state, and the events still owed.
    // ------------------------------------------------------------------------
    class line_editor_scoreboard;
        bit          line_output_enable = 1'b0;
        bit          shift_held = 1'b0;
        bit          ctrl_held = 1'b0;
        bit          alt_held = 1'b0;
        bit          caps_on = 1'b0;
        bit [6:0]    line_store [LINE_DEPTH];
        int          line_length = 0;
        line_event_t owed_events [$];
        int          error_count = 0;

        function int outstanding();
            return owed_events.size();
        endfunction

        function void owe_event(kind_t kind, bit [6:0] char_code);
            line_event_t ev;
            ev.kind      = kind;
            ev.char_code = char_code;
            ev.last      = 1'b0;
            ev.ctrl_down = ctrl_held;
            ev.alt_down  = alt_held;
            owed_events.push_back(ev);
        endfunction

        // Shift picks the table; caps swaps the case of letters only.
        function bit [6:0] key_to_ascii(int idx);
            bit [7:0] c;
            if (shift_held) begin
                c = SHIFTED_KEYS[8*(TABLE_LEN-1-idx) +: 8];
                if (caps_on && c >= "A" && c <= "Z")
                    c = c + 8'h20;
            end else begin
                c = UNSHIFTED_KEYS[8*(TABLE_LEN-1-idx) +: 8];
                if (caps_on && c >= "a" && c <= "z")
                    c = c - 8'h20;
            end
            return c[6:0];
        endfunction

        function void apply_scancode(bit [7:0] code);
            bit [6:0]    key;
            bit [6:0]    ch;
            int          first;
            line_event_t tail;
            key   = code[6:0];
            first = owed_events.size();
            if (code[7]) begin
                if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                    shift_held = 1'b0;
                else if (key == KEY_CTRL)
                    ctrl_held = 1'b0;
                else if (key == KEY_ALT)
                    alt_held = 1'b0;
                return;
            end
            if (key > KEY_MAX)
                return;
            case (key)
                KEY_BACKSPACE: begin
                    if (line_length > 0) begin
                        line_length--;
                        owe_event(KIND_BACKSPACE, 7'd0);
                    end
                end
                KEY_ENTER: begin
                    owe_event(KIND_ECHO, CHAR_NEWLINE);
                    if (line_output_enable) begin
                        for (int i = 0; i < line_length; i++)
                            owe_event(KIND_LINE_CHAR, line_store[i]);
                        owe_event(KIND_LINE_END, 7'd0);
                    end
                    line_length = 0;
                end
                KEY_LSHIFT, KEY_RSHIFT: shift_held = 1'b1;
                KEY_CTRL:               ctrl_held = 1'b1;
                KEY_ALT:                alt_held = 1'b1;
                KEY_CAPS:               caps_on = ~caps_on;
                default: begin
                    ch = key_to_ascii(int'(key));
                    if (line_length >= LINE_DEPTH) begin
                        owe_event(KIND_DROPPED, ch);
                    end else begin
                        line_store[line_length] = ch;
                        line_length++;
                        owe_event(KIND_ECHO, ch);
                    end
                end
            endcase
            if (owed_events.size() > first) begin
                tail = owed_events.pop_back();
                tail.last = 1'b1;
                owed_events.push_back(tail);
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            error_count++;
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_event(kind_t kind, bit [6:0] char_code, bit last, bit ctrl_down,
                         bit alt_down);
            line_event_t want;
            if (owed_events.size() == 0) begin
                report_mismatch("unexpected output item, kind", int'(kind), -1);
                return;
            end
            want = owed_events.pop_front();
            if (kind != want.kind)
                report_mismatch("kind", int'(kind), int'(want.kind));
            if (char_code != want.char_code)
                report_mismatch("char_code", char_code, want.char_code);
            if (last != want.last)
                report_mismatch("last", last, want.last);
            if (ctrl_down != want.ctrl_down)
                report_mismatch("ctrl_down", ctrl_down, want.ctrl_down);
            if (alt_down != want.alt_down)
                report_mismatch("alt_down", alt_down, want.alt_down);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [7:0] scancode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [6:0] char_code, [7] ctrl_down, [8] alt_down
    logic [2:0]  m_tuser;           // [2:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = 1'b0;   // [0] line_output_enable

    scancode_line_editor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    line_editor_scoreboard board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;

    // Opening keys: shift and caps case rules, both modifiers, ignored bytes,
    // backspace with and without a buffered character, and one enter.
    bit [7:0] opening_keys [0:26] = '{
        8'd30,                  // 'a'
        {1'b0, KEY_LSHIFT},
        8'd30,                  // 'A'
        8'd2,                   // '!'
        {1'b1, KEY_LSHIFT},
        {1'b0, KEY_CAPS},
        8'd16,                  // caps only: 'Q'
        8'd2,                   // caps leaves digits alone
        {1'b0, KEY_RSHIFT},
        8'd16,                  // shift and caps: 'q'
        8'd0,                   // first table entry
        {1'b1, KEY_RSHIFT},
        {1'b0, KEY_CAPS},
        {1'b0, KEY_CTRL},
        {1'b0, KEY_ALT},
        8'd57,                  // space, carries both modifier flags
        {1'b1, KEY_CTRL},
        {1'b1, KEY_ALT},
        8'h9E,                  // release of a letter key does nothing
        8'd59,                  // first press beyond the table
        8'h7F,
        {1'b0, KEY_BACKSPACE},
        8'd15,                  // tab
        8'd1,
        {1'b0, KEY_ENTER},
        {1'b0, KEY_BACKSPACE},  // empty line, no output
        8'hFF
    };

    always #6 aclk = ~aclk;

    // The receiver throttles on its own, one decision per cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every output item is checked at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_event(kind_t'(m_tuser), m_tdata[6:0], m_tlast, m_tdata[7],
                              m_tdata[8]);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Each is entered and left just after a falling edge; tvalid is
    // left high after an item so back-to-back items need no second write.
    // ------------------------------------------------------------------------
    task automatic drive_scancode(input bit [7:0] code);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge aclk); while (!s_tready);
        board.apply_scancode(code);
        @(negedge aclk);
    endtask

    // The register is only written while the editor has nothing in flight.
    task automatic write_line_output_enable(input bit enable);
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        do @(posedge aclk); while (!cfg_ready);
        board.line_output_enable = enable;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off new keys until every owed item has arrived, then let the
    // editor settle for settle_cycles to finish any key that produces nothing.
    task automatic drain_editor(input int settle_cycles);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (settle_cycles) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic bit [6:0] pick_modifier();
        case ($urandom_range(0, 4))
            0:       return KEY_LSHIFT;
            1:       return KEY_RSHIFT;
            2:       return KEY_CTRL;
            3:       return KEY_ALT;
            default: return KEY_CAPS;
        endcase
    endfunction

    // A character key: any table entry that is not an editing or modifier key.
    task automatic type_random_key();
        bit [6:0] key;
        do
            key = 7'($urandom_range(0, 57));
        while (key == KEY_BACKSPACE || key == KEY_ENTER || key == KEY_CTRL ||
               key == KEY_LSHIFT || key == KEY_RSHIFT || key == KEY_ALT);
        drive_scancode({1'b0, key});
    endtask

    // Random typing: mostly characters, with edits, modifier traffic and some
    // bytes the editor throws away. Thrown-away bytes are not counted.
    task automatic type_random_session(input int n_keys);
        int typed;
        int roll;
        typed = 0;
        while (typed < n_keys) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                type_random_key();
                typed++;
            end else if (roll < 63) begin
                drive_scancode({1'b0, KEY_BACKSPACE});
                typed++;
            end else if (roll < 71) begin
                drive_scancode({1'b0, KEY_ENTER});
                typed++;
            end else if (roll < 81) begin
                drive_scancode({1'b0, pick_modifier()});
                typed++;
            end else if (roll < 91) begin
                drive_scancode({1'b1, pick_modifier()});
                typed++;
            end else if (roll < 96) begin
                drive_scancode(8'($urandom_range(128, 255)));
            end else begin
                drive_scancode(8'($urandom_range(59, 127)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase one: slow sender, very slow receiver, lines emitted on enter.
        send_idle_pct = 23;
        recv_idle_pct = 84;
        write_line_output_enable(1'b1);
        foreach (opening_keys[i])
            drive_scancode(opening_keys[i]);
        type_random_session(5);

        // Phase two: roles swapped, enter only clears the line.
        drain_editor(SETTLE_WAIT);
        send_idle_pct = 84;
        recv_idle_pct = 23;
        write_line_output_enable(1'b0);
        type_random_session(5);

        // Phase three: no idling. Overfill one line so the last keys are
        // dropped, then enter emits the longest possible burst.
        drain_editor(SETTLE_WAIT);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_line_output_enable(1'b1);
        drive_scancode({1'b0, KEY_ENTER});
        repeat (LINE_DEPTH + 2)
            type_random_key();
        drive_scancode({1'b0, KEY_ENTER});
        type_random_session(2);

        drain_editor(FINAL_WAIT);
        if (board.error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
